### rtl/dfw_pkg.sv
// Shared widths, codes and types of the disparity row forward warp.
`default_nettype none
package dfw_pkg;

  localparam int MAX_ROW_WIDTH_DEF = 4096;
  localparam int PIXEL_BITS_DEF    = 16;

  localparam int KIND_W     = 2;
  localparam int POS_W      = 12;
  localparam int DISP_W     = 18;
  localparam int GAIN_W     = 11;
  localparam int RWID_W     = 13;
  localparam int PROD_W     = DISP_W + GAIN_W + 1;
  localparam int FRAC_W     = 16;
  localparam int OFS_W      = PROD_W - FRAC_W;
  localparam int TGT_W      = 16;
  localparam int ADDR_MAX_W = 14;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;
  localparam int Q_DEPTH    = 2;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] REG_EYE   = 2'd0;
  localparam logic [1:0] REG_GAIN  = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = 11'd256;
  localparam logic [RWID_W-1:0] WIDTH_RESET = 13'd4096;

  typedef struct packed {
    logic              eye_select;
    logic [GAIN_W-1:0] gain;
    logic [RWID_W-1:0] row_width;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]     op;
    logic [POS_W-1:0]      position;
    logic [ADDR_MAX_W-1:0] target;
    logic                  scatter_ok;
    logic                  read_ok;
  } entry_t;

endpackage
`default_nettype wire

### rtl/dfw_in_if.sv
// Input channel interface: command beats with pixel and disparities.
`default_nettype none
interface dfw_in_if #(
  parameter int PIXEL_BITS = dfw_pkg::PIXEL_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [dfw_pkg::KIND_W-1:0]        kind;
  logic [dfw_pkg::POS_W-1:0]         position;
  logic [PIXEL_BITS-1:0]             pixel_value;
  logic signed [dfw_pkg::DISP_W-1:0] disparity_red;
  logic signed [dfw_pkg::DISP_W-1:0] disparity_green;

  modport source (
    output valid, kind, position, pixel_value, disparity_red, disparity_green,
    input  ready
  );
  modport sink (
    input  valid, kind, position, pixel_value, disparity_red, disparity_green,
    output ready
  );
endinterface
`default_nettype wire

### rtl/dfw_out_if.sv
// Result channel interface: warped output pixel beats.
`default_nettype none
interface dfw_out_if #(
  parameter int PIXEL_BITS = dfw_pkg::PIXEL_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [dfw_pkg::POS_W-1:0]  out_position;
  logic [PIXEL_BITS-1:0]      out_value;

  modport source (output valid, out_position, out_value, input ready);
  modport sink   (input valid, out_position, out_value, output ready);
endinterface
`default_nettype wire

### rtl/disparity_row_forward_warp.sv
// Top level of the disparity row forward warp.
//
//   Channel   Direction   Handshake            Payload
//   in_bus    sink        valid/ready          kind, position, pixel_value, disparities
//   out_bus   source      valid/ready          out_position, out_value
//   APB       slave       psel/penable/pready  eye_select, disparity_gain, row_width
//
// In the back end a load beat steps through the base write (LOAD_B) and the scatter
// write (LOAD_C), a read beat through READ; mark and row memory have one read port each.
// A start beat clears the marks, one entry per cycle.
// After reset the same clearing pass runs before any beat is taken.
// A two-entry queue lets the front end keep taking beats while the back end or the
// result register stalls.
`default_nettype none
module disparity_row_forward_warp #(
  parameter int MAX_ROW_WIDTH = dfw_pkg::MAX_ROW_WIDTH_DEF,
  parameter int PIXEL_BITS    = dfw_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  dfw_in_if.sink                           in_bus,
  dfw_out_if.source                        out_bus,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dfw_pkg::APB_AW-1:0]  paddr,
  input  wire logic [dfw_pkg::APB_DW-1:0]  pwdata,
  output logic      [dfw_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  localparam int QW = $bits(dfw_pkg::entry_t) + PIXEL_BITS;

  dfw_pkg::cfg_t          cfg;
  logic                   init_done;
  logic                   fq_valid, fq_ready;
  dfw_pkg::entry_t        fq_entry;
  logic [PIXEL_BITS-1:0]  fq_val;
  logic                   qb_valid, qb_ready;
  logic [QW-1:0]          qb_data;
  dfw_pkg::entry_t        qb_entry;
  logic [PIXEL_BITS-1:0]  qb_val;

  assign qb_entry = qb_data[QW-1:PIXEL_BITS];
  assign qb_val   = qb_data[PIXEL_BITS-1:0];

  dfw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dfw_front #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg       (cfg),
    .init_done (init_done),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_entry   (fq_entry),
    .q_val     (fq_val)
  );

  dfw_queue #(
    .W (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  ({fq_entry, fq_val}),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  dfw_back #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_entry   (qb_entry),
    .q_val     (qb_val),
    .init_done (init_done),
    .out_bus   (out_bus)
  );
endmodule
`default_nettype wire

### rtl/dfw_regs.sv
// APB configuration registers of the forward warp.
`default_nettype none
module dfw_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dfw_pkg::APB_AW-1:0]  paddr,
  input  wire logic [dfw_pkg::APB_DW-1:0]  pwdata,
  output logic      [dfw_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output dfw_pkg::cfg_t                    cfg
);
  logic                         eye_r;
  logic [dfw_pkg::GAIN_W-1:0]   gain_r;
  logic [dfw_pkg::RWID_W-1:0]   width_r;
  logic                         wr_en;
  logic [1:0]                   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r   <= 1'b0;
      gain_r  <= dfw_pkg::GAIN_RESET;
      width_r <= dfw_pkg::WIDTH_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        dfw_pkg::REG_EYE:   eye_r   <= pwdata[0];
        dfw_pkg::REG_GAIN:  gain_r  <= pwdata[dfw_pkg::GAIN_W-1:0];
        dfw_pkg::REG_WIDTH: width_r <= pwdata[dfw_pkg::RWID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dfw_pkg::REG_EYE:   prdata = dfw_pkg::APB_DW'(eye_r);
      dfw_pkg::REG_GAIN:  prdata = dfw_pkg::APB_DW'(gain_r);
      dfw_pkg::REG_WIDTH: prdata = dfw_pkg::APB_DW'(width_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.eye_select = eye_r;
  assign cfg.gain       = gain_r;
  assign cfg.row_width  = width_r;
endmodule
`default_nettype wire

### rtl/dfw_front.sv
// Front end: accepts beats, scales disparity, computes and checks targets.
`default_nettype none
module dfw_front #(
  parameter int MAX_ROW_WIDTH = dfw_pkg::MAX_ROW_WIDTH_DEF,
  parameter int PIXEL_BITS    = dfw_pkg::PIXEL_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  dfw_in_if.sink             in_bus,
  input  wire dfw_pkg::cfg_t cfg,
  input  wire logic          init_done,
  output logic               q_valid,
  input  wire logic          q_ready,
  output dfw_pkg::entry_t    q_entry,
  output logic [PIXEL_BITS-1:0] q_val
);
  localparam int WW0 = $clog2(MAX_ROW_WIDTH + 1);
  localparam int WW  = (WW0 > dfw_pkg::RWID_W) ? WW0 : dfw_pkg::RWID_W;

  logic                                f_valid_r;
  logic [dfw_pkg::KIND_W-1:0]          f_kind_r;
  logic [dfw_pkg::POS_W-1:0]           f_pos_r;
  logic [PIXEL_BITS-1:0]               f_val_r;
  logic signed [dfw_pkg::PROD_W-1:0]   f_prod_r;

  logic                                in_acc;
  logic                                f_keep;
  logic                                f_free;
  logic signed [dfw_pkg::DISP_W-1:0]   disp_sel;
  logic signed [dfw_pkg::PROD_W-1:0]   prod;
  logic signed [dfw_pkg::PROD_W-1:0]   prod_adj;
  logic signed [dfw_pkg::OFS_W-1:0]    offset;
  logic signed [dfw_pkg::TGT_W-1:0]    pos_s;
  logic signed [dfw_pkg::TGT_W-1:0]    target;
  logic [WW-1:0]                       width_req;
  logic [WW-1:0]                       width_eff;
  logic                                pos_in;
  logic                                tgt_in;

  assign disp_sel = cfg.eye_select ? in_bus.disparity_green : in_bus.disparity_red;
  assign prod     = dfw_pkg::PROD_W'(disp_sel) *
                    $signed({1'b0, cfg.gain});

  assign width_req = WW'(cfg.row_width);
  assign width_eff = (width_req > WW'(MAX_ROW_WIDTH)) ? WW'(MAX_ROW_WIDTH) : width_req;
  assign pos_in    = WW'(f_pos_r) < width_eff;

  // Truncation toward zero: bias negative products before the shift.
  assign prod_adj = f_prod_r[dfw_pkg::PROD_W-1] ?
                    f_prod_r + dfw_pkg::PROD_W'(17'h0FFFF) : f_prod_r;
  assign offset   = prod_adj[dfw_pkg::PROD_W-1:dfw_pkg::FRAC_W];
  assign pos_s    = $signed({{(dfw_pkg::TGT_W-dfw_pkg::POS_W){1'b0}}, f_pos_r});
  assign target   = cfg.eye_select ? pos_s - dfw_pkg::TGT_W'(offset)
                                   : pos_s + dfw_pkg::TGT_W'(offset);
  assign tgt_in   = !target[dfw_pkg::TGT_W-1] &&
                    ($unsigned(target) < dfw_pkg::TGT_W'(width_eff));

  always_comb begin
    case (f_kind_r)
      dfw_pkg::KIND_START: f_keep = 1'b1;
      dfw_pkg::KIND_LOAD:  f_keep = pos_in;
      dfw_pkg::KIND_READ:  f_keep = 1'b1;
      default:             f_keep = 1'b0;
    endcase
  end

  assign f_free       = !f_valid_r || !f_keep || q_ready;
  assign in_bus.ready = init_done && f_free;
  assign in_acc       = in_bus.valid && in_bus.ready;

  assign q_valid             = f_valid_r && f_keep;
  assign q_entry.op          = f_kind_r;
  assign q_entry.position    = f_pos_r;
  assign q_entry.target      = target[dfw_pkg::ADDR_MAX_W-1:0];
  assign q_entry.scatter_ok  = tgt_in;
  assign q_entry.read_ok     = dfw_pkg::TGT_W'(f_pos_r) < dfw_pkg::TGT_W'(MAX_ROW_WIDTH);
  assign q_val               = f_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= in_acc || (f_valid_r && !f_free);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_kind_r <= in_bus.kind;
      f_pos_r  <= in_bus.position;
      f_val_r  <= in_bus.pixel_value;
      f_prod_r <= prod;
    end
  end
endmodule
`default_nettype wire

### rtl/dfw_queue.sv
// Short FIFO between the front end and the back end.
`default_nettype none
module dfw_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output logic [W-1:0]      rd_data
);
  localparam int DEPTH = dfw_pkg::Q_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  buf_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] count_r;
  logic          push;
  logic          pop;

  assign wr_ready = count_r != CW'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = buf_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= wr_data;
    end
  end
endmodule
`default_nettype wire

### rtl/dfw_back.sv
// Back end: row and mark memories, scatter sequencer, mark sweep, result register.
`default_nettype none
module dfw_back #(
  parameter int MAX_ROW_WIDTH = dfw_pkg::MAX_ROW_WIDTH_DEF,
  parameter int PIXEL_BITS    = dfw_pkg::PIXEL_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dfw_pkg::cfg_t    cfg,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire dfw_pkg::entry_t  q_entry,
  input  wire logic [PIXEL_BITS-1:0] q_val,
  output logic                  init_done,
  dfw_out_if.source             out_bus
);
  localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int XW = (AW > dfw_pkg::POS_W) ? AW : dfw_pkg::POS_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOAD_B = 3'd2;
  localparam logic [2:0] ST_LOAD_C = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  logic [PIXEL_BITS-1:0] row_mem  [MAX_ROW_WIDTH];
  logic                  mark_mem [MAX_ROW_WIDTH];

  logic [2:0]              state_r, state_nxt;
  logic [AW-1:0]           cnt_r, cnt_nxt;
  logic                    init_done_r, init_done_nxt;
  dfw_pkg::entry_t         cur_r, cur_nxt;
  logic [PIXEL_BITS-1:0]   val_r, val_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [dfw_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [PIXEL_BITS-1:0]   out_val_r, out_val_nxt;
  logic [PIXEL_BITS-1:0]   row_rd_r;
  logic                    mark_rd_r;

  logic                    row_we;
  logic [AW-1:0]           row_waddr;
  logic [PIXEL_BITS-1:0]   row_wdata;
  logic [AW-1:0]           row_raddr;
  logic                    mark_we;
  logic [AW-1:0]           mark_waddr;
  logic                    mark_wdata;
  logic [AW-1:0]           mark_raddr;
  logic                    out_free;
  logic [XW-1:0]           head_pos_x;
  logic [XW-1:0]           cur_pos_x;
  logic [AW-1:0]           head_addr;
  logic [AW-1:0]           cur_addr;
  logic [AW-1:0]           tgt_addr;

  assign head_pos_x = XW'(q_entry.position);
  assign cur_pos_x  = XW'(cur_r.position);
  assign head_addr  = head_pos_x[AW-1:0];
  assign cur_addr   = cur_pos_x[AW-1:0];
  assign tgt_addr   = cur_r.target[AW-1:0];

  assign out_free = !out_valid_r || out_bus.ready;
  assign q_ready  = (state_r == ST_IDLE) &&
                    ((q_entry.op != dfw_pkg::KIND_READ) || out_free);

  assign row_raddr  = head_addr;
  assign mark_raddr = (state_r == ST_IDLE) ? head_addr : tgt_addr;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    init_done_nxt = init_done_r;
    cur_nxt       = cur_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    row_we        = 1'b0;
    row_waddr     = cur_addr;
    row_wdata     = val_r;
    mark_we       = 1'b0;
    mark_waddr    = tgt_addr;
    mark_wdata    = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = cnt_r;
        mark_wdata = 1'b0;
        if (cnt_r == AW'(MAX_ROW_WIDTH - 1)) begin
          state_nxt     = ST_IDLE;
          init_done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid && q_ready) begin
          cur_nxt = q_entry;
          val_nxt = q_val;
          case (q_entry.op)
            dfw_pkg::KIND_START: begin
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            dfw_pkg::KIND_LOAD: state_nxt = ST_LOAD_B;
            dfw_pkg::KIND_READ: state_nxt = ST_READ;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_B: begin
        // Base write keeps the source value unless a scatter already landed here.
        row_we    = !mark_rd_r;
        state_nxt = ST_LOAD_C;
      end
      ST_LOAD_C: begin
        if (cur_r.scatter_ok && (!cfg.eye_select || !mark_rd_r)) begin
          row_we    = 1'b1;
          row_waddr = tgt_addr;
          mark_we   = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_pos_nxt   = cur_r.position;
        out_val_nxt   = cur_r.read_ok ? row_rd_r : '0;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      init_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      init_done_r <= init_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    val_r     <= val_nxt;
    out_pos_r <= out_pos_nxt;
    out_val_r <= out_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rd_r <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd_r <= mark_mem[mark_raddr];
  end

  assign init_done            = init_done_r;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_position = out_pos_r;
  assign out_bus.out_value    = out_val_r;

`ifndef ASSERT_OFF
  a_load_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD_C) |-> ($past(state_r) == ST_LOAD_B))
    else $error("scatter step without a preceding base step");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("result register occupied when a read completes");

  a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid_r)
    else $error("read did not produce a result beat");

  a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    init_done_r |=> init_done_r)
    else $error("initial sweep flag dropped");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !q_ready)
    else $error("queue popped while the sequencer is busy");
`endif
endmodule
`default_nettype wire

### tb/disparity_row_forward_warp_tb.sv
// Self-checking testbench for the disparity row forward warp with randomized traffic.
module disparity_row_forward_warp_tb;

  localparam logic [dfw_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int PIX_W = dfw_pkg::PIXEL_BITS_DEF;
  localparam int ROW_MAX = dfw_pkg::MAX_ROW_WIDTH_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int N_PHASES = 10;

  typedef struct {
    logic [dfw_pkg::KIND_W-1:0]        kind;
    logic [dfw_pkg::POS_W-1:0]         position;
    logic [PIX_W-1:0]                  pixel_value;
    logic signed [dfw_pkg::DISP_W-1:0] disparity_red;
    logic signed [dfw_pkg::DISP_W-1:0] disparity_green;
    bit                                hold;
  } warp_beat_t;

  typedef struct {
    logic [dfw_pkg::POS_W-1:0] position;
    logic [PIX_W-1:0]          value;
  } warped_pixel_t;

  int unsigned ph_eye   [N_PHASES] = '{0, 0, 1, 0, 1, 1, 0, 1, 0, 1};
  int unsigned ph_gain  [N_PHASES] = '{256, 256, 256, 1280, 0, 1280, 700, 2047, 0, 128};
  int unsigned ph_width [N_PHASES] = '{4096, 16, 16, 1, 4096, 37, 64, 8191, 0, 8};
  int unsigned ph_items [N_PHASES] = '{80, 150, 150, 60, 80, 150, 150, 80, 30, 150};

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [dfw_pkg::APB_AW-1:0] paddr;
  logic [dfw_pkg::APB_DW-1:0] pwdata;
  logic [dfw_pkg::APB_DW-1:0] prdata;
  logic pready;

  dfw_in_if  in_ch ();
  dfw_out_if out_ch ();

  disparity_row_forward_warp uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic                       cfg_eye = 1'b0;
  logic [dfw_pkg::GAIN_W-1:0] cfg_gain = dfw_pkg::GAIN_RESET;
  logic [dfw_pkg::RWID_W-1:0] cfg_width = dfw_pkg::WIDTH_RESET;

  logic [PIX_W-1:0] warped_row [ROW_MAX];
  bit scatter_marked [ROW_MAX];
  bit row_entry_set [ROW_MAX];
  int set_positions [$];

  warp_beat_t beats_to_send [$];
  warped_pixel_t pixels_due [$];
  warp_beat_t cur_beat;
  warped_pixel_t want;

  int n_errors = 0;
  int quiet_cycles = 0;
  int gen_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  always #5 clk = ~clk;

  function automatic longint row_limit();
    return (cfg_width > ROW_MAX) ? longint'(ROW_MAX) : longint'(cfg_width);
  endfunction

  function automatic longint warp_target(logic [dfw_pkg::POS_W-1:0] pos,
                                         logic signed [dfw_pkg::DISP_W-1:0] dr,
                                         logic signed [dfw_pkg::DISP_W-1:0] dg);
    longint shift;
    shift = (longint'(cfg_eye ? dg : dr) * longint'(cfg_gain)) / 65536;
    return cfg_eye ? longint'(pos) - shift : longint'(pos) + shift;
  endfunction

  task automatic apply_warp_beat(input warp_beat_t b);
    longint w, p, t;
    warped_pixel_t px;
    w = row_limit();
    p = longint'(b.position);
    case (b.kind)
      dfw_pkg::KIND_START: scatter_marked = '{default: 1'b0};
      dfw_pkg::KIND_LOAD: if (p < w) begin
        if (!scatter_marked[p]) warped_row[p] = b.pixel_value;
        t = warp_target(b.position, b.disparity_red, b.disparity_green);
        if (t >= 0 && t < w && !(cfg_eye && scatter_marked[t])) begin
          warped_row[t] = b.pixel_value;
          scatter_marked[t] = 1'b1;
        end
      end
      dfw_pkg::KIND_READ: begin
        px.position = b.position;
        px.value = warped_row[p];
        pixels_due.push_back(px);
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [dfw_pkg::DISP_W-1:0] rand_disp();
    int unsigned r;
    int span;
    logic [31:0] raw;
    r = $urandom_range(0, 99);
    span = (r < 60) ? 8 * 256 : 64 * 256;
    if (r >= 85) raw = $urandom;
    else raw = $urandom_range(0, 2 * span) - span;
    return raw[dfw_pkg::DISP_W-1:0];
  endfunction

  task automatic note_written(input longint pos);
    if (!row_entry_set[pos]) begin
      row_entry_set[pos] = 1'b1;
      set_positions.push_back(int'(pos));
    end
  endtask

  task automatic push_fixed(input logic [dfw_pkg::KIND_W-1:0] k, input int pos,
                            input logic [PIX_W-1:0] pix,
                            input logic signed [dfw_pkg::DISP_W-1:0] dr,
                            input logic signed [dfw_pkg::DISP_W-1:0] dg);
    warp_beat_t b;
    longint t;
    b.kind = k;
    b.position = pos[dfw_pkg::POS_W-1:0];
    b.pixel_value = pix;
    b.disparity_red = dr;
    b.disparity_green = dg;
    b.hold = 1'b0;
    beats_to_send.push_back(b);
    gen_count++;
    if (k == dfw_pkg::KIND_LOAD && longint'(b.position) < row_limit()) begin
      note_written(longint'(b.position));
      t = warp_target(b.position, dr, dg);
      if (t >= 0 && t < row_limit()) note_written(t);
    end
  endtask

  task automatic push_beat(input logic [dfw_pkg::KIND_W-1:0] k, input int pos);
    push_fixed(k, pos, $urandom_range(0, 65535), rand_disp(), rand_disp());
  endtask

  task automatic push_hold();
    warp_beat_t b;
    b = '{kind: KIND_SPARE, position: '0, pixel_value: '0, disparity_red: '0,
          disparity_green: '0, hold: 1'b1};
    beats_to_send.push_back(b);
  endtask

  function automatic int pick_written();
    return set_positions[$urandom_range(0, set_positions.size() - 1)];
  endfunction

  task automatic push_row();
    int w, len, base, n;
    w = int'(row_limit());
    len = (w <= 64) ? w : $urandom_range(8, 24);
    if (w <= 64) base = 0;
    else if ($urandom_range(0, 3) == 0) base = w - len;
    else base = $urandom_range(0, w - len);
    push_beat(dfw_pkg::KIND_START, $urandom_range(0, 4095));
    if ($urandom_range(0, 6) == 0) begin
      for (int i = len - 1; i >= 0; i--) push_beat(dfw_pkg::KIND_LOAD, base + i);
    end else begin
      for (int i = 0; i < len; i++) push_beat(dfw_pkg::KIND_LOAD, base + i);
    end
    n = $urandom_range(2, 8);
    for (int i = 0; i < n; i++) begin
      if (len > 0 && $urandom_range(0, 1) == 1)
        push_beat(dfw_pkg::KIND_READ, base + $urandom_range(0, len - 1));
      else push_beat(dfw_pkg::KIND_READ, pick_written());
    end
    if ($urandom_range(0, 9) == 0) push_hold();
  endtask

  task automatic push_noise();
    int w;
    w = int'(row_limit());
    case ($urandom_range(0, 5))
      0: push_beat(KIND_SPARE, $urandom_range(0, 4095));
      1: push_beat(dfw_pkg::KIND_LOAD, $urandom_range(0, 4095));
      2: push_beat(dfw_pkg::KIND_READ, pick_written());
      3: push_beat(dfw_pkg::KIND_START, $urandom_range(0, 4095));
      4: push_beat(dfw_pkg::KIND_LOAD,
                   (w > 0) ? $urandom_range(0, w - 1) : $urandom_range(0, 4095));
      default: begin
        push_hold();
        push_beat(dfw_pkg::KIND_READ, pick_written());
      end
    endcase
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [dfw_pkg::APB_DW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      dfw_pkg::REG_EYE:   cfg_eye = val[0];
      dfw_pkg::REG_GAIN:  cfg_gain = val[dfw_pkg::GAIN_W-1:0];
      dfw_pkg::REG_WIDTH: cfg_width = val[dfw_pkg::RWID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_ch.valid || pixels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) apply_warp_beat(cur_beat);
      if (!in_ch.valid || in_ch.ready) begin
        if (beats_to_send.size() != 0 && beats_to_send[0].hold) begin
          if (pixels_due.size() == 0) beats_to_send.delete(0);
          in_ch.valid <= 1'b0;
        end else if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_beat = beats_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= cur_beat.kind;
          in_ch.position <= cur_beat.position;
          in_ch.pixel_value <= cur_beat.pixel_value;
          in_ch.disparity_red <= cur_beat.disparity_red;
          in_ch.disparity_green <= cur_beat.disparity_green;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_due.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected beat, expected none, actual position %0d value 0x%04h",
                   $time, out_ch.out_position, out_ch.out_value);
        end else begin
          want = pixels_due.pop_front();
          if (out_ch.out_position !== want.position) begin
            n_errors++;
            $display("%0t: out_position expected %0d actual %0d",
                     $time, want.position, out_ch.out_position);
          end
          if (out_ch.out_value !== want.value) begin
            n_errors++;
            $display("%0t: out_value at position %0d expected 0x%04h actual 0x%04h",
                     $time, want.position, want.value, out_ch.out_value);
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: timeout with %0d beats pending", $time, pixels_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = dfw_pkg::KIND_START;
    in_ch.position = '0;
    in_ch.pixel_value = '0;
    in_ch.disparity_red = '0;
    in_ch.disparity_green = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        wait_drained();
        reg_write(dfw_pkg::REG_EYE, ph_eye[ph]);
        reg_write(dfw_pkg::REG_GAIN, ph_gain[ph]);
        reg_write(dfw_pkg::REG_WIDTH, ph_width[ph]);
      end
      idle_pct = (ph % 4 == 1) ? 75 : (ph % 4 == 3) ? 31 : 0;
      stall_pct = (ph % 4 == 2) ? 75 : (ph % 4 == 3) ? 31 : 0;
      @(negedge clk);
      if (ph == 0) begin
        // Zero offset lands on itself, far offsets fall off either end, two
        // writers collide, a marked position keeps its scatter, and a new
        // start clears the marks again.
        push_fixed(dfw_pkg::KIND_START, 0, 16'h0000, 18'sd0, 18'sd0);
        push_fixed(dfw_pkg::KIND_LOAD, 0, 16'h0000, 18'sd0, -18'sd131072);
        push_fixed(dfw_pkg::KIND_LOAD, 4095, 16'hFFFF, 18'sd131071, 18'sd131071);
        push_fixed(dfw_pkg::KIND_LOAD, 10, 16'h04D2, -18'sd131072, 18'sd0);
        push_fixed(dfw_pkg::KIND_LOAD, 20, 16'h0005, 18'sd768, 18'sd0);
        push_fixed(dfw_pkg::KIND_LOAD, 21, 16'h0006, 18'sd512, 18'sd0);
        push_fixed(dfw_pkg::KIND_LOAD, 23, 16'h0007, 18'sd256, 18'sd0);
        push_fixed(dfw_pkg::KIND_LOAD, 30, 16'h0008, -18'sd255, 18'sd0);
        push_fixed(dfw_pkg::KIND_LOAD, 40, 16'h0009, -18'sd256, 18'sd0);
        push_fixed(KIND_SPARE, 4095, 16'hFFFF, -18'sd1, -18'sd1);
        push_beat(dfw_pkg::KIND_READ, 0);
        push_beat(dfw_pkg::KIND_READ, 4095);
        push_beat(dfw_pkg::KIND_READ, 10);
        push_beat(dfw_pkg::KIND_READ, 20);
        push_beat(dfw_pkg::KIND_READ, 21);
        push_beat(dfw_pkg::KIND_READ, 23);
        push_beat(dfw_pkg::KIND_READ, 24);
        push_beat(dfw_pkg::KIND_READ, 30);
        push_beat(dfw_pkg::KIND_READ, 39);
        push_hold();
        push_fixed(dfw_pkg::KIND_START, 4095, 16'hFFFF, -18'sd1, -18'sd1);
        push_fixed(dfw_pkg::KIND_LOAD, 23, 16'h0063, 18'sd0, 18'sd0);
        push_beat(dfw_pkg::KIND_READ, 23);
        push_beat(dfw_pkg::KIND_READ, 40);
      end
      gen_count = 0;
      while (gen_count < ph_items[ph]) begin
        if ($urandom_range(0, 99) < 70) push_row();
        else push_noise();
      end
      push_beat(dfw_pkg::KIND_READ, pick_written());
    end
    wait_drained();
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
